// ----- sv/mmcp_pkg.sv -----
package mmcp_pkg;

	localparam int NUM_REGIONS_DEF = 16;
	localparam int MAX_RES = 64;
	localparam int WALK_BOUND = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic CMD_PRIO = 1'b0;
	localparam logic CMD_CUBE = 1'b1;

	// Partner code of a face edge whose segment runs to the face center.
	localparam logic [2:0] PART_CTR = 3'd4;

	localparam logic [4:0] VC_FACE0 = 5'd12;
	localparam logic [4:0] VC_CUBE = 5'd18;

	typedef logic signed [4:0] region_t;

	localparam logic [2:0] FACE_V [6][4] = '{
		'{3'd0, 3'd1, 3'd2, 3'd3}, '{3'd4, 3'd5, 3'd0, 3'd1}, '{3'd4, 3'd0, 3'd6, 3'd2},
		'{3'd1, 3'd5, 3'd3, 3'd7}, '{3'd2, 3'd3, 3'd6, 3'd7}, '{3'd6, 3'd7, 3'd4, 3'd5}};

	localparam logic [3:0] FACE_E [6][4] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3}, '{4'd8, 4'd4, 4'd0, 4'd5}, '{4'd4, 4'd9, 4'd6, 4'd1},
		'{4'd5, 4'd3, 4'd7, 4'd11}, '{4'd2, 4'd6, 4'd10, 4'd7}, '{4'd10, 4'd9, 4'd8, 4'd11}};

	localparam logic [2:0] EDGE_END [12][2] = '{
		'{3'd0, 3'd1}, '{3'd0, 3'd2}, '{3'd2, 3'd3}, '{3'd1, 3'd3}, '{3'd0, 3'd4}, '{3'd1, 3'd5},
		'{3'd2, 3'd6}, '{3'd3, 3'd7}, '{3'd4, 3'd5}, '{3'd4, 3'd6}, '{3'd6, 3'd7}, '{3'd5, 3'd7}};

	// The two faces that share each edge, lower face first, and the edge's place in each.
	localparam logic [2:0] EDGE_F [12][2] = '{
		'{3'd0, 3'd1}, '{3'd0, 3'd2}, '{3'd0, 3'd4}, '{3'd0, 3'd3}, '{3'd1, 3'd2}, '{3'd1, 3'd3},
		'{3'd2, 3'd4}, '{3'd3, 3'd4}, '{3'd1, 3'd5}, '{3'd2, 3'd5}, '{3'd4, 3'd5}, '{3'd3, 3'd5}};

	localparam logic [1:0] EDGE_P [12][2] = '{
		'{2'd0, 2'd2}, '{2'd1, 2'd3}, '{2'd2, 2'd0}, '{2'd3, 2'd1}, '{2'd1, 2'd0}, '{2'd3, 2'd0},
		'{2'd2, 2'd1}, '{2'd2, 2'd3}, '{2'd0, 2'd2}, '{2'd1, 2'd1}, '{2'd2, 2'd0}, '{2'd3, 2'd3}};

	typedef struct packed {
		logic [3:0]       seg_v;
		logic [3:0][2:0]  part;
		logic [2:0]       ctr_n;
		logic [3:0][1:0]  ctr_pos;
	} face_info_t;

	typedef struct packed {
		region_t [7:0]     corner;
		face_info_t [5:0]  face;
	} cube_rec_t;

	typedef struct packed {
		logic [2:0] face;
		logic       actr;
		logic [3:0] a;
		logic [3:0] b;
	} seg_t;

	typedef struct packed {
		logic [1:0] n;
		seg_t       s0;
		seg_t       s1;
	} edge_look_t;

endpackage

// ----- sv/mmcp_in_if.sv -----
interface mmcp_in_if;
	logic              valid;
	logic              ready;
	logic              cmd;
	logic signed [4:0] corner_region_0;
	logic signed [4:0] corner_region_1;
	logic signed [4:0] corner_region_2;
	logic signed [4:0] corner_region_3;
	logic signed [4:0] corner_region_4;
	logic signed [4:0] corner_region_5;
	logic signed [4:0] corner_region_6;
	logic signed [4:0] corner_region_7;
	logic [3:0]        priority_slot;
	logic [4:0]        priority_level;

	modport source (output valid, cmd, corner_region_0, corner_region_1, corner_region_2,
		corner_region_3, corner_region_4, corner_region_5, corner_region_6, corner_region_7,
		priority_slot, priority_level, input ready);
	modport sink (input valid, cmd, corner_region_0, corner_region_1, corner_region_2,
		corner_region_3, corner_region_4, corner_region_5, corner_region_6, corner_region_7,
		priority_slot, priority_level, output ready);
endinterface

// ----- sv/mmcp_out_if.sv -----
interface mmcp_out_if;
	logic              valid;
	logic              ready;
	logic [4:0]        vertex_code;
	logic signed [4:0] region_low;
	logic signed [4:0] region_high;
	logic              polyline_end;
	logic              cube_last;
	logic              center_error;

	modport source (output valid, vertex_code, region_low, region_high, polyline_end,
		cube_last, center_error, input ready);
	modport sink (input valid, vertex_code, region_low, region_high, polyline_end,
		cube_last, center_error, output ready);
endinterface

// ----- sv/mmcp_front.sv -----
module mmcp_front #(
	parameter int NUM_REGIONS = mmcp_pkg::NUM_REGIONS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mmcp_in_if.sink               items,
	output logic                  push_v,
	output mmcp_pkg::cube_rec_t   push_rec,
	input  logic                  push_rdy
);

	localparam int AW = $clog2(NUM_REGIONS);

	typedef enum logic [1:0] {F_IDLE, F_RD, F_CL, F_PUSH} fstate_t;

	fstate_t               state_q;
	logic [2:0]            face_q;
	mmcp_pkg::cube_rec_t   rec_q;
	logic [4:0]            prio_mem [NUM_REGIONS];
	logic [NUM_REGIONS-1:0] prio_ok_q;
	logic [4:0]            lo_pr_q, hi_pr_q;
	logic                  lo_ok_q, hi_ok_q;

	logic                  accept;
	logic [7:0]            wa8, lo_a8, hi_a8;
	logic [AW-1:0]         waddr, lo_addr, hi_addr;
	logic                  slot_ok, lo_in, hi_in;
	mmcp_pkg::region_t     r [4];
	mmcp_pkg::region_t     oth, lo, hi;
	logic [4:0]            plo, phi;

	function automatic mmcp_pkg::face_info_t add_pair(mmcp_pkg::face_info_t fi,
		logic [1:0] i, logic [1:0] j);
		mmcp_pkg::face_info_t t;
		t = fi;
		t.seg_v[i] = 1'b1;
		t.part[i] = {1'b0, j};
		t.seg_v[j] = 1'b1;
		t.part[j] = {1'b0, i};
		return t;
	endfunction

	function automatic mmcp_pkg::face_info_t add_ctr(mmcp_pkg::face_info_t fi, logic [1:0] i);
		mmcp_pkg::face_info_t t;
		t = fi;
		t.seg_v[i] = 1'b1;
		t.part[i] = mmcp_pkg::PART_CTR;
		t.ctr_pos[t.ctr_n[1:0]] = i;
		t.ctr_n = t.ctr_n + 3'd1;
		return t;
	endfunction

	function automatic mmcp_pkg::face_info_t classify(mmcp_pkg::region_t r0,
		mmcp_pkg::region_t r1, mmcp_pkg::region_t r2, mmcp_pkg::region_t r3,
		logic [4:0] pl, logic [4:0] ph);
		mmcp_pkg::face_info_t fi;
		mmcp_pkg::region_t o, l, h, lone, top;
		logic [2:0] nd, nlo;
		fi = '0;
		nd = 3'd1 + {2'b0, r1 != r0} + {2'b0, (r2 != r0) && (r2 != r1)}
			+ {2'b0, (r3 != r0) && (r3 != r1) && (r3 != r2)};
		o = (r1 != r0) ? r1 : ((r2 != r0) ? r2 : r3);
		l = (r0 < o) ? r0 : o;
		h = (r0 < o) ? o : r0;
		nlo = {2'b0, r0 == l} + {2'b0, r1 == l} + {2'b0, r2 == l} + {2'b0, r3 == l};
		if (nd == 3'd2) begin
			if (nlo == 3'd2) begin
				if (r0 == r3) begin
					// Diagonal face: the preferred region keeps its corners joined.
					top = l;
					if (h[4] || (!l[4] && (pl < ph))) top = h;
					if (r0 == top) begin
						fi = add_pair(fi, 2'd1, 2'd2);
						fi = add_pair(fi, 2'd0, 2'd3);
					end else begin
						fi = add_pair(fi, 2'd0, 2'd1);
						fi = add_pair(fi, 2'd2, 2'd3);
					end
				end else if (r0 == r1) begin
					fi = add_pair(fi, 2'd1, 2'd3);
				end else if (r0 == r2) begin
					fi = add_pair(fi, 2'd0, 2'd2);
				end
			end else begin
				lone = (nlo == 3'd3) ? h : l;
				if (r0 == lone) fi = add_pair(fi, 2'd0, 2'd1);
				else if (r1 == lone) fi = add_pair(fi, 2'd0, 2'd3);
				else if (r2 == lone) fi = add_pair(fi, 2'd1, 2'd2);
				else fi = add_pair(fi, 2'd2, 2'd3);
			end
		end else if (nd == 3'd3) begin
			if (r0 == r3) begin
				fi = add_pair(fi, 2'd1, 2'd2);
				fi = add_pair(fi, 2'd0, 2'd3);
			end else if (r1 == r2) begin
				fi = add_pair(fi, 2'd0, 2'd1);
				fi = add_pair(fi, 2'd2, 2'd3);
			end else if (r0 == r1) begin
				fi = add_ctr(fi, 2'd1);
				fi = add_ctr(fi, 2'd3);
				fi = add_ctr(fi, 2'd2);
			end else if (r0 == r2) begin
				fi = add_ctr(fi, 2'd0);
				fi = add_ctr(fi, 2'd2);
				fi = add_ctr(fi, 2'd3);
			end else if (r1 == r3) begin
				fi = add_ctr(fi, 2'd0);
				fi = add_ctr(fi, 2'd2);
				fi = add_ctr(fi, 2'd1);
			end else if (r2 == r3) begin
				fi = add_ctr(fi, 2'd1);
				fi = add_ctr(fi, 2'd3);
				fi = add_ctr(fi, 2'd0);
			end
		end else if (nd == 3'd4) begin
			fi = add_ctr(fi, 2'd0);
			fi = add_ctr(fi, 2'd1);
			fi = add_ctr(fi, 2'd2);
			fi = add_ctr(fi, 2'd3);
		end
		return fi;
	endfunction

	assign items.ready = (state_q == F_IDLE);
	assign accept = items.valid && items.ready;
	assign push_v = (state_q == F_PUSH);
	assign push_rec = rec_q;

	always_comb begin
		for (int i = 0; i < 4; i++) r[i] = rec_q.corner[mmcp_pkg::FACE_V[face_q][i]];
		oth = (r[1] != r[0]) ? r[1] : ((r[2] != r[0]) ? r[2] : r[3]);
		lo = (r[0] < oth) ? r[0] : oth;
		hi = (r[0] < oth) ? oth : r[0];
		wa8 = {4'b0, items.priority_slot};
		lo_a8 = {4'b0, lo[3:0]};
		hi_a8 = {4'b0, hi[3:0]};
		waddr = wa8[AW-1:0];
		lo_addr = lo_a8[AW-1:0];
		hi_addr = hi_a8[AW-1:0];
		slot_ok = int'(items.priority_slot) < NUM_REGIONS;
		lo_in = !lo[4] && (int'(lo[3:0]) < NUM_REGIONS);
		hi_in = !hi[4] && (int'(hi[3:0]) < NUM_REGIONS);
		plo = lo_ok_q ? lo_pr_q : 5'd0;
		phi = hi_ok_q ? hi_pr_q : 5'd0;
	end

	always_ff @(posedge clk) begin
		if (accept && (items.cmd == mmcp_pkg::CMD_PRIO) && slot_ok)
			prio_mem[waddr] <= items.priority_level;
		if (state_q == F_RD) begin
			lo_pr_q <= prio_mem[lo_addr];
			hi_pr_q <= prio_mem[hi_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			face_q <= '0;
			prio_ok_q <= '0;
			lo_ok_q <= 1'b0;
			hi_ok_q <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (items.cmd == mmcp_pkg::CMD_CUBE) begin
							rec_q.corner <= {items.corner_region_7, items.corner_region_6,
								items.corner_region_5, items.corner_region_4,
								items.corner_region_3, items.corner_region_2,
								items.corner_region_1, items.corner_region_0};
							face_q <= '0;
							state_q <= F_RD;
						end else if (slot_ok) begin
							prio_ok_q[waddr] <= 1'b1;
						end
					end
				end
				F_RD: begin
					lo_ok_q <= lo_in && prio_ok_q[lo_addr];
					hi_ok_q <= hi_in && prio_ok_q[hi_addr];
					state_q <= F_CL;
				end
				F_CL: begin
					rec_q.face[face_q] <= classify(r[0], r[1], r[2], r[3], plo, phi);
					if (face_q == 3'd5) begin
						state_q <= F_PUSH;
					end else begin
						face_q <= face_q + 3'd1;
						state_q <= F_RD;
					end
				end
				F_PUSH: begin
					if (push_rdy) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/mmcp_queue.sv -----
module mmcp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_v,
	input  mmcp_pkg::cube_rec_t  push_rec,
	output logic                 push_rdy,
	input  logic                 pop,
	output logic                 pop_v,
	output mmcp_pkg::cube_rec_t  pop_rec
);

	localparam int QW = (mmcp_pkg::QUEUE_DEPTH > 1) ? $clog2(mmcp_pkg::QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(mmcp_pkg::QUEUE_DEPTH + 1);

	mmcp_pkg::cube_rec_t mem_q [mmcp_pkg::QUEUE_DEPTH];
	logic [QW-1:0] wp_q, rp_q;
	logic [NW-1:0] n_q;
	logic do_push, do_pop;

	function automatic logic [QW-1:0] bump(logic [QW-1:0] p);
		return (p == QW'(mmcp_pkg::QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
	endfunction

	assign push_rdy = (n_q != NW'(mmcp_pkg::QUEUE_DEPTH));
	assign pop_v = (n_q != '0);
	assign pop_rec = mem_q[rp_q];
	assign do_push = push_v && push_rdy;
	assign do_pop = pop && pop_v;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			n_q <= '0;
		end else begin
			if (do_push) wp_q <= bump(wp_q);
			if (do_pop) rp_q <= bump(rp_q);
			if (do_push && !do_pop) n_q <= n_q + NW'(1);
			else if (do_pop && !do_push) n_q <= n_q - NW'(1);
		end
	end

endmodule

// ----- sv/mmcp_back.sv -----
module mmcp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_v,
	input  mmcp_pkg::cube_rec_t  pop_rec,
	output logic                 pop,
	mmcp_out_if.source           results
);

	localparam int CW = $clog2(mmcp_pkg::MAX_RES + 1);

	typedef enum logic [3:0] {
		B_IDLE, B_START, B_CSCAN, B_C18, B_CFACE, B_CSTEP, B_CEND, B_LSCAN, B_LSTEP, B_FIN
	} bstate_t;

	bstate_t               state_q;
	mmcp_pkg::cube_rec_t   rec_q;
	logic [11:0]           visited_q;
	logic [5:0][3:0]       done_q;
	logic [2:0]            f_q, endf_q;
	logic [1:0]            c_q;
	logic [3:0]            i_q, cur_q, step_q;
	mmcp_pkg::seg_t        last_q;
	mmcp_pkg::region_t     lo_q, hi_q;
	logic [CW-1:0]         cnt_q;
	logic                  poly_q;

	logic                  pend_v_q, pend_end_q, perr_q;
	logic [4:0]            pc_q;
	mmcp_pkg::region_t     plo_q, phi_q;

	logic                  ov_q, oend_q, ocl_q, oerr_q;
	logic [4:0]            oc_q;
	mmcp_pkg::region_t     olo_q, ohi_q;

	logic [2:0]            centers;
	mmcp_pkg::edge_look_t  look, lk_i;
	mmcp_pkg::seg_t        nxt, l0, l1;
	logic [3:0]            cstep_next, nx, e0;
	logic                  l_found, l_close, mfound;
	logic [1:0]            mk;
	logic [5:0][3:0]       done_nx;
	mmcp_pkg::face_info_t  fi_c, fi_e;
	logic                  can_emit, em_req, em_end, em_err, em_take, em_drop_close;
	logic                  mv, flush;
	logic [4:0]            em_code;

	function automatic mmcp_pkg::seg_t mkseg(logic [2:0] f, logic [3:0] e, logic [2:0] part);
		mmcp_pkg::seg_t s;
		logic [3:0] o;
		s = '0;
		s.face = f;
		if (part == mmcp_pkg::PART_CTR) begin
			s.actr = 1'b1;
			s.b = e;
		end else begin
			o = mmcp_pkg::FACE_E[f][part[1:0]];
			s.a = (e < o) ? e : o;
			s.b = (e < o) ? o : e;
		end
		return s;
	endfunction

	// Segments held on one edge, in the order the faces laid them down.
	function automatic mmcp_pkg::edge_look_t on_edge(mmcp_pkg::cube_rec_t rec, logic [3:0] e);
		mmcp_pkg::edge_look_t lk;
		mmcp_pkg::face_info_t fi;
		mmcp_pkg::seg_t s;
		logic [2:0] fa;
		logic [1:0] pa;
		lk = '0;
		for (int k = 0; k < 2; k++) begin
			fa = mmcp_pkg::EDGE_F[e][k];
			pa = mmcp_pkg::EDGE_P[e][k];
			fi = rec.face[fa];
			if (fi.seg_v[pa]) begin
				s = mkseg(fa, e, fi.part[pa]);
				if (lk.n == 2'd0) lk.s0 = s;
				else lk.s1 = s;
				lk.n = lk.n + 2'd1;
			end
		end
		return lk;
	endfunction

	function automatic logic [9:0] edge_pair(mmcp_pkg::cube_rec_t rec, logic [3:0] e);
		mmcp_pkg::region_t x, y;
		x = rec.corner[mmcp_pkg::EDGE_END[e][0]];
		y = rec.corner[mmcp_pkg::EDGE_END[e][1]];
		return (x < y) ? {x, y} : {y, x};
	endfunction

	function automatic logic [3:0] seg_edge(mmcp_pkg::seg_t s);
		return s.actr ? s.b : s.a;
	endfunction

	// The edge being emitted this cycle counts as visited already.
	function automatic logic is_seen(logic [3:0] x, logic ctr, logic [11:0] vis,
		logic [3:0] cur);
		return ctr || vis[x] || (x == cur);
	endfunction

	always_comb begin
		centers = '0;
		for (int f = 0; f < 6; f++)
			centers = centers + {2'b0, rec_q.face[f].ctr_n != 3'd0};

		look = on_edge(rec_q, cur_q);
		lk_i = on_edge(rec_q, i_q);

		nxt = look.s0;
		if ((nxt == last_q) && (look.n > 2'd1)) nxt = look.s1;
		if (!is_seen(nxt.a, nxt.actr, visited_q, cur_q)) cstep_next = nxt.a;
		else if (!is_seen(nxt.b, 1'b0, visited_q, cur_q)) cstep_next = nxt.b;
		else cstep_next = cur_q;

		l0 = look.s0;
		l1 = (look.n > 2'd1) ? look.s1 : look.s0;
		l_found = 1'b1;
		if (!is_seen(l0.a, l0.actr, visited_q, cur_q)) nx = l0.a;
		else if (!is_seen(l0.b, 1'b0, visited_q, cur_q)) nx = l0.b;
		else if (!is_seen(l1.a, l1.actr, visited_q, cur_q)) nx = l1.a;
		else if (!is_seen(l1.b, 1'b0, visited_q, cur_q)) nx = l1.b;
		else begin
			nx = cur_q;
			l_found = 1'b0;
		end
		l_close = !l_found || (step_q == 4'(mmcp_pkg::WALK_BOUND - 1));

		fi_c = rec_q.face[f_q];
		e0 = mmcp_pkg::FACE_E[f_q][fi_c.ctr_pos[c_q]];

		fi_e = rec_q.face[endf_q];
		mfound = 1'b0;
		mk = '0;
		for (int k = 0; k < 4; k++) begin
			if (!mfound && (k < int'(fi_e.ctr_n)) && (edge_pair(rec_q,
				mmcp_pkg::FACE_E[endf_q][fi_e.ctr_pos[k]]) == {lo_q, hi_q})) begin
				mfound = 1'b1;
				mk = 2'(k);
			end
		end

		done_nx = done_q;
		done_nx[f_q][c_q] = 1'b1;
		if (mfound) done_nx[endf_q][mk] = 1'b1;

		em_req = 1'b0;
		em_end = 1'b0;
		em_err = 1'b0;
		em_code = '0;
		case (state_q)
			B_START: begin
				em_req = (centers == 3'd1);
				em_err = 1'b1;
			end
			B_C18: begin
				em_req = 1'b1;
				em_code = mmcp_pkg::VC_CUBE;
			end
			B_CFACE: begin
				em_req = 1'b1;
				em_code = mmcp_pkg::VC_FACE0 + {2'b0, f_q};
			end
			B_CSTEP: begin
				em_req = 1'b1;
				em_code = {1'b0, cur_q};
			end
			B_CEND: begin
				em_req = 1'b1;
				em_end = 1'b1;
				em_code = mmcp_pkg::VC_FACE0 + {2'b0, endf_q};
			end
			B_LSTEP: begin
				em_req = 1'b1;
				em_end = l_close;
				em_code = {1'b0, cur_q};
			end
			default: em_req = 1'b0;
		endcase

		// A new word may enter the pending slot once its old word can move on.
		can_emit = !pend_v_q || !ov_q || results.ready;
		em_take = em_req && can_emit && (cnt_q < CW'(mmcp_pkg::MAX_RES));
		em_drop_close = em_req && can_emit && !(cnt_q < CW'(mmcp_pkg::MAX_RES)) && em_end
			&& poly_q;
		flush = (state_q == B_FIN) && pend_v_q && (!ov_q || results.ready);
		mv = (em_take && pend_v_q) || flush;
	end

	assign pop = (state_q == B_IDLE) && pop_v;

	assign results.valid = ov_q;
	assign results.vertex_code = oc_q;
	assign results.region_low = olo_q;
	assign results.region_high = ohi_q;
	assign results.polyline_end = oend_q;
	assign results.cube_last = ocl_q;
	assign results.center_error = oerr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			pend_v_q <= 1'b0;
			ov_q <= 1'b0;
			cnt_q <= '0;
			visited_q <= '0;
			done_q <= '0;
			f_q <= '0;
			c_q <= '0;
			i_q <= '0;
			cur_q <= '0;
			step_q <= '0;
			endf_q <= '0;
			poly_q <= 1'b0;
		end else begin
			if (mv) begin
				ov_q <= 1'b1;
				oc_q <= pc_q;
				olo_q <= plo_q;
				ohi_q <= phi_q;
				oend_q <= pend_end_q;
				oerr_q <= perr_q;
				ocl_q <= flush;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end

			if (em_take) begin
				pend_v_q <= 1'b1;
				pc_q <= em_code;
				plo_q <= em_err ? '0 : lo_q;
				phi_q <= em_err ? '0 : hi_q;
				pend_end_q <= em_end;
				perr_q <= em_err;
				cnt_q <= cnt_q + CW'(1);
				poly_q <= 1'b1;
			end else if (flush) begin
				pend_v_q <= 1'b0;
			end else if (em_drop_close) begin
				pend_end_q <= 1'b1;
			end

			unique case (state_q)
				B_IDLE: begin
					if (pop_v) begin
						rec_q <= pop_rec;
						visited_q <= '0;
						done_q <= '0;
						cnt_q <= '0;
						state_q <= B_START;
					end
				end
				B_START: begin
					if (centers == 3'd1) begin
						if (can_emit) state_q <= B_FIN;
					end else if (centers == 3'd0) begin
						i_q <= '0;
						state_q <= B_LSCAN;
					end else begin
						f_q <= '0;
						c_q <= '0;
						state_q <= B_CSCAN;
					end
				end
				B_CSCAN: begin
					if (({1'b0, c_q} < fi_c.ctr_n) && !done_q[f_q][c_q]) begin
						last_q <= mkseg(f_q, e0, mmcp_pkg::PART_CTR);
						cur_q <= e0;
						endf_q <= f_q;
						{lo_q, hi_q} <= edge_pair(rec_q, e0);
						step_q <= '0;
						poly_q <= 1'b0;
						state_q <= (centers > 3'd2) ? B_C18 : B_CFACE;
					end else if (({1'b0, c_q} + 3'd1) < fi_c.ctr_n) begin
						c_q <= c_q + 2'd1;
					end else begin
						c_q <= '0;
						if (f_q == 3'd5) begin
							i_q <= '0;
							state_q <= B_LSCAN;
						end else begin
							f_q <= f_q + 3'd1;
						end
					end
				end
				B_C18: begin
					if (can_emit) state_q <= B_CFACE;
				end
				B_CFACE: begin
					if (can_emit) state_q <= B_CSTEP;
				end
				B_CSTEP: begin
					if (can_emit) begin
						visited_q[cur_q] <= 1'b1;
						if (nxt.actr) begin
							endf_q <= nxt.face;
							state_q <= B_CEND;
						end else begin
							cur_q <= cstep_next;
							last_q <= nxt;
							if (step_q == 4'(mmcp_pkg::WALK_BOUND - 1)) state_q <= B_CEND;
							else step_q <= step_q + 4'd1;
						end
					end
				end
				B_CEND: begin
					if (can_emit) begin
						done_q <= done_nx;
						state_q <= B_CSCAN;
					end
				end
				B_LSCAN: begin
					if (!visited_q[i_q] && (lk_i.n != 2'd0)) begin
						cur_q <= i_q;
						step_q <= '0;
						poly_q <= 1'b0;
						{lo_q, hi_q} <= edge_pair(rec_q, seg_edge(lk_i.s0));
						state_q <= B_LSTEP;
					end else if (i_q == 4'd11) begin
						state_q <= B_FIN;
					end else begin
						i_q <= i_q + 4'd1;
					end
				end
				B_LSTEP: begin
					if (can_emit) begin
						visited_q[cur_q] <= 1'b1;
						if (l_close) begin
							state_q <= B_LSCAN;
						end else begin
							cur_q <= nx;
							step_q <= step_q + 4'd1;
						end
					end
				end
				B_FIN: begin
					if (!pend_v_q || flush) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(mmcp_pkg::MAX_RES))
		else $error("result count ran past its bound");

	a_idle_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_IDLE) |-> !pend_v_q)
		else $error("word left pending between cubes");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && oerr_q) |-> (ocl_q && !oend_q))
		else $error("error word not marked as last of its cube");

	a_walk_edge: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == B_CSTEP) || (state_q == B_LSTEP)) |-> (cur_q < 4'd12))
		else $error("walk left the edge range");
`endif

endmodule

// ----- sv/multi_material_cube_polylines_unit.sv -----
// A cube holds the front from its accept through a priority memory read and a face
// classification for each face, and then until the queue takes it. The back emits only
// an error word for a single-center cube and only scans the edges of a uniform one;
// otherwise it emits vertex words and scans for new polylines, and walks stop at their bound.
// arst_n clears all control state and the valid bits of the priority table, so every
// priority reads zero after reset; no clearing pass is needed.
module multi_material_cube_polylines_unit #(
	parameter int NUM_REGIONS = mmcp_pkg::NUM_REGIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mmcp_in_if.sink     items,
	mmcp_out_if.source  results
);

	logic                 push_v, push_rdy, pop, pop_v;
	mmcp_pkg::cube_rec_t  push_rec, pop_rec;

	mmcp_front #(.NUM_REGIONS(NUM_REGIONS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.push_v   (push_v),
		.push_rec (push_rec),
		.push_rdy (push_rdy)
	);

	mmcp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_v   (push_v),
		.push_rec (push_rec),
		.push_rdy (push_rdy),
		.pop      (pop),
		.pop_v    (pop_v),
		.pop_rec  (pop_rec)
	);

	mmcp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.pop_v   (pop_v),
		.pop_rec (pop_rec),
		.pop     (pop),
		.results (results)
	);

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

	typedef struct packed {
		logic              cmd;
		logic [7:0][4:0]   crn;
		logic [3:0]        slot;
		logic [4:0]        level;
	} word_t;

	typedef struct packed {
		logic [4:0] code;
		logic [4:0] lo;
		logic [4:0] hi;
		logic       pend;
		logic       last;
		logic       err;
	} vert_t;

	typedef struct {
		int face;
		int a;
		int b;
	} line_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mmcp_in_if  items ();
	mmcp_out_if results ();

	multi_material_cube_polylines_unit dut (
		.clk(clk), .arst_n(arst_n), .items(items.sink), .results(results.source)
	);

	word_t pending_words[$];
	vert_t expected_verts[$];
	int errors = 0;
	int sender_idle_pct = 21;
	int receiver_idle_pct = 65;
	bit hold_until_drained = 1'b0;
	int quiet_cycles = 0;

	logic [4:0] prio_mem [16];
	int cr[8];
	line_t on_edge[12][2];
	int on_edge_n[12];
	line_t ctr[6][4];
	int ctr_n[6];
	bit ctr_done[6][4];
	bit seen_edge[12];
	vert_t obuf[$];

	function automatic void queue_word(word_t w);
		pending_words.insert(pending_words.size(), w);
	endfunction

	function automatic int pr(int id);
		if (id < 0 || id >= 16) return 0;
		return prio_mem[id];
	endfunction

	function automatic void put_segment(int f, int la, int lb);
		int ea;
		int eb;
		line_t s;
		ea = la < 0 ? -1 : mmcp_pkg::FACE_E[f][la];
		eb = lb < 0 ? -1 : mmcp_pkg::FACE_E[f][lb];
		s.face = f;
		s.a = ea < eb ? ea : eb;
		s.b = ea < eb ? eb : ea;
		if (s.a < 0 && ctr_n[f] < 4) begin
			ctr[f][ctr_n[f]] = s;
			ctr_n[f]++;
		end
		if (s.a >= 0 && on_edge_n[s.a] < 2) begin
			on_edge[s.a][on_edge_n[s.a]] = s;
			on_edge_n[s.a]++;
		end
		if (s.b >= 0 && on_edge_n[s.b] < 2) begin
			on_edge[s.b][on_edge_n[s.b]] = s;
			on_edge_n[s.b]++;
		end
	endfunction

	function automatic void pair_of(line_t s, output int lo, output int hi);
		int e;
		int x;
		int y;
		e = s.a >= 0 ? s.a : s.b;
		if (e < 0 || e > 11) e = 0;
		x = cr[mmcp_pkg::EDGE_END[e][0]];
		y = cr[mmcp_pkg::EDGE_END[e][1]];
		lo = x < y ? x : y;
		hi = x < y ? y : x;
	endfunction

	function automatic void push_vert(int code, int lo, int hi);
		vert_t v;
		if (obuf.size() >= mmcp_pkg::MAX_RES) return;
		v = '0;
		v.code = code[4:0];
		v.lo = lo[4:0];
		v.hi = hi[4:0];
		obuf.insert(obuf.size(), v);
	endfunction

	function automatic void end_poly(int start);
		if (obuf.size() > start) obuf[obuf.size() - 1].pend = 1'b1;
	endfunction

	function automatic void classify(int f);
		int r[4];
		int d[4];
		int nd;
		int lo;
		int hi;
		int nlo;
		int top;
		int lone;
		bit seen;
		nd = 0;
		for (int i = 0; i < 4; i++) begin
			seen = 0;
			r[i] = cr[mmcp_pkg::FACE_V[f][i]];
			for (int j = 0; j < nd; j++) if (d[j] == r[i]) seen = 1;
			if (!seen) begin
				d[nd] = r[i];
				nd++;
			end
		end
		if (nd == 2) begin
			lo = d[0] < d[1] ? d[0] : d[1];
			hi = d[0] < d[1] ? d[1] : d[0];
			nlo = 0;
			for (int i = 0; i < 4; i++) if (r[i] == lo) nlo++;
			if (nlo == 2) begin
				if (r[0] == r[3]) begin
					top = lo;
					if (hi < 0 || (lo >= 0 && pr(lo) < pr(hi))) top = hi;
					if (r[0] == top) begin
						put_segment(f, 1, 2); put_segment(f, 0, 3);
					end else begin
						put_segment(f, 0, 1); put_segment(f, 2, 3);
					end
				end else if (r[0] == r[1]) put_segment(f, 1, 3);
				else if (r[0] == r[2]) put_segment(f, 0, 2);
			end else begin
				lone = (nlo == 3) ? hi : lo;
				if (r[0] == lone) put_segment(f, 0, 1);
				else if (r[1] == lone) put_segment(f, 0, 3);
				else if (r[2] == lone) put_segment(f, 1, 2);
				else put_segment(f, 2, 3);
			end
		end else if (nd == 3) begin
			if (r[0] == r[3]) begin
				put_segment(f, 1, 2); put_segment(f, 0, 3);
			end else if (r[1] == r[2]) begin
				put_segment(f, 0, 1); put_segment(f, 2, 3);
			end else if (r[0] == r[1]) begin
				put_segment(f, 1, -1); put_segment(f, 3, -1); put_segment(f, 2, -1);
			end else if (r[0] == r[2]) begin
				put_segment(f, 0, -1); put_segment(f, 2, -1); put_segment(f, 3, -1);
			end else if (r[1] == r[3]) begin
				put_segment(f, 0, -1); put_segment(f, 2, -1); put_segment(f, 1, -1);
			end else if (r[2] == r[3]) begin
				put_segment(f, 1, -1); put_segment(f, 3, -1); put_segment(f, 0, -1);
			end
		end else if (nd == 4) begin
			put_segment(f, 0, -1); put_segment(f, 1, -1);
			put_segment(f, 2, -1); put_segment(f, 3, -1);
		end
	endfunction

	function automatic bit is_done(int e);
		return e < 0 || e > 11 || seen_edge[e];
	endfunction

	function automatic bit same_line(line_t x, line_t y);
		return x.face == y.face && x.a == y.a && x.b == y.b;
	endfunction

	function automatic void chain_from_center(int f, int c, int centers);
		line_t prev;
		line_t nxt;
		int lo;
		int hi;
		int l2;
		int h2;
		int cur;
		int end_f;
		int start;
		prev = ctr[f][c];
		cur = prev.b;
		end_f = f;
		start = obuf.size();
		pair_of(prev, lo, hi);
		if (centers > 2) push_vert(mmcp_pkg::VC_CUBE, lo, hi);
		push_vert(mmcp_pkg::VC_FACE0 + f, lo, hi);
		for (int step = 0; step < mmcp_pkg::WALK_BOUND && cur >= 0 && cur < 12; step++) begin
			seen_edge[cur] = 1;
			push_vert(cur, lo, hi);
			nxt = on_edge[cur][0];
			if (same_line(nxt, prev) && on_edge_n[cur] > 1) nxt = on_edge[cur][1];
			if (nxt.a < 0) begin
				end_f = nxt.face;
				break;
			end
			if (!is_done(nxt.a)) cur = nxt.a;
			else if (!is_done(nxt.b)) cur = nxt.b;
			prev = nxt;
		end
		push_vert(mmcp_pkg::VC_FACE0 + end_f, lo, hi);
		end_poly(start);
		ctr_done[f][c] = 1;
		for (int k = 0; k < ctr_n[end_f]; k++) begin
			pair_of(ctr[end_f][k], l2, h2);
			if (l2 == lo && h2 == hi) begin
				ctr_done[end_f][k] = 1;
				break;
			end
		end
	endfunction

	function automatic void closed_loop(int e);
		line_t l0;
		line_t l1;
		int cand[4];
		int lo;
		int hi;
		int cur;
		int nx;
		int start;
		cur = e;
		start = obuf.size();
		pair_of(on_edge[e][0], lo, hi);
		for (int step = 0; step < mmcp_pkg::WALK_BOUND; step++) begin
			l0 = on_edge[cur][0];
			l1 = on_edge_n[cur] > 1 ? on_edge[cur][1] : l0;
			nx = -1;
			seen_edge[cur] = 1;
			push_vert(cur, lo, hi);
			cand[0] = l0.a; cand[1] = l0.b; cand[2] = l1.a; cand[3] = l1.b;
			for (int k = 0; k < 4; k++) if (!is_done(cand[k])) begin
				nx = cand[k];
				break;
			end
			if (nx < 0) break;
			cur = nx;
		end
		end_poly(start);
	endfunction

	function automatic void predict_polylines(word_t w);
		int centers;
		vert_t v;
		if (w.cmd == mmcp_pkg::CMD_PRIO) begin
			prio_mem[w.slot] = w.level;
			return;
		end
		for (int i = 0; i < 8; i++) cr[i] = $signed(w.crn[i]);
		for (int i = 0; i < 12; i++) begin
			on_edge_n[i] = 0;
			seen_edge[i] = 0;
		end
		for (int f = 0; f < 6; f++) begin
			ctr_n[f] = 0;
			for (int k = 0; k < 4; k++) ctr_done[f][k] = 0;
		end
		obuf.delete();
		centers = 0;
		for (int f = 0; f < 6; f++) begin
			classify(f);
			if (ctr_n[f] > 0) centers++;
		end
		if (centers == 1) begin
			v = '0;
			v.last = 1'b1;
			v.err = 1'b1;
			expected_verts.insert(expected_verts.size(), v);
			return;
		end
		if (centers > 0)
			for (int f = 0; f < 6; f++)
				for (int i = 0; i < ctr_n[f]; i++)
					if (!ctr_done[f][i]) chain_from_center(f, i, centers);
		for (int i = 0; i < 12; i++)
			if (!seen_edge[i] && on_edge_n[i] > 0) closed_loop(i);
		if (obuf.size() > 0) obuf[obuf.size() - 1].last = 1'b1;
		foreach (obuf[i]) expected_verts.insert(expected_verts.size(), obuf[i]);
	endfunction

	task automatic report_mismatch(string what, vert_t got, vert_t want);
		$display("vertex mismatch (%s): got %h want %h", what, got, want);
		errors++;
	endtask

	function automatic logic [4:0] rnd_region(int nreg);
		return 5'($signed($urandom_range(nreg, 0)) - 1);
	endfunction

	function automatic word_t cube_word(int c0, int c1, int c2, int c3, int c4, int c5,
		int c6, int c7);
		word_t w;
		w = '0;
		w.cmd = mmcp_pkg::CMD_CUBE;
		w.crn[0] = c0[4:0]; w.crn[1] = c1[4:0]; w.crn[2] = c2[4:0]; w.crn[3] = c3[4:0];
		w.crn[4] = c4[4:0]; w.crn[5] = c5[4:0]; w.crn[6] = c6[4:0]; w.crn[7] = c7[4:0];
		w.slot = 4'($urandom);
		w.level = 5'($urandom);
		return w;
	endfunction

	function automatic word_t prio_word(int slot, int level);
		word_t w;
		w = '0;
		w.cmd = mmcp_pkg::CMD_PRIO;
		w.slot = slot[3:0];
		w.level = level[4:0];
		for (int i = 0; i < 8; i++) w.crn[i] = 5'($urandom);
		return w;
	endfunction

	function automatic word_t random_word();
		word_t w;
		int nreg;
		int mode;
		mode = $urandom_range(99, 0);
		if (mode < 12) return prio_word($urandom_range(15, 0), $urandom_range(16, 0));
		nreg = $urandom_range(4, 1);
		w = cube_word(0, 0, 0, 0, 0, 0, 0, 0);
		for (int i = 0; i < 8; i++) begin
			if (mode < 20) w.crn[i] = 5'($urandom);
			else if (mode < 60) w.crn[i] = rnd_region(nreg);
			else w.crn[i] = $urandom_range(1, 0) ? 5'($urandom_range(15, 0)) : 5'h1f;
		end
		return w;
	endfunction

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		items.valid = 1'b0;
		items.cmd = 1'b0;
		items.corner_region_0 = '0; items.corner_region_1 = '0;
		items.corner_region_2 = '0; items.corner_region_3 = '0;
		items.corner_region_4 = '0; items.corner_region_5 = '0;
		items.corner_region_6 = '0; items.corner_region_7 = '0;
		items.priority_slot = '0;
		items.priority_level = '0;
		results.ready = 1'b0;
		for (int i = 0; i < 16; i++) prio_mem[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, diagonals with ties and priorities, the empty marker.
		queue_word(cube_word(3, 3, 3, 3, 3, 3, 3, 3));
		queue_word(cube_word(-1, 0, 0, -1, 0, 0, 0, 0));
		queue_word(cube_word(2, 5, 5, 2, 2, 2, 2, 2));
		queue_word(prio_word(5, 16));
		queue_word(prio_word(15, 31));
		queue_word(prio_word(0, 0));
		queue_word(cube_word(2, 5, 5, 2, 2, 2, 2, 2));
		queue_word(cube_word(15, -1, 15, 15, 15, 15, 15, 15));
		queue_word(cube_word(0, 1, 2, 3, 4, 5, 6, 7));
		queue_word(cube_word(-16, 15, -2, 7, 0, -1, 3, 9));
		queue_word(cube_word(0, 1, 2, 0, 0, 0, 0, 0));
		queue_word(cube_word(0, 0, 0, 0, 1, 1, 1, 1));
		queue_word(cube_word(-1, -1, -1, -1, -1, -1, -1, 0));
		queue_word(cube_word(0, 1, 1, 0, 1, 0, 0, 1));
		queue_word(cube_word(-16, -16, -16, -16, -16, -16, -16, -16));
		for (int i = 0; i < 16; i++) queue_word(prio_word(i, i));
		queue_word(cube_word(3, 9, 9, 3, 3, 3, 3, 3));
		for (int i = 0; i < 50; i++) queue_word(random_word());
		wait (pending_words.size() == 0 && !items.valid);

		hold_until_drained = 1'b1;
		wait (expected_verts.size() == 0);
		repeat (120) @(posedge clk);
		hold_until_drained = 1'b0;
		sender_idle_pct = 65;
		receiver_idle_pct = 21;
		for (int i = 0; i < 16; i++) queue_word(prio_word(i, 16 - i));
		for (int i = 0; i < 50; i++) queue_word(random_word());
		wait (pending_words.size() == 0);

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		for (int i = 0; i < 50; i++) queue_word(random_word());
		wait (pending_words.size() == 0 && !items.valid);
		wait (expected_verts.size() == 0);
		repeat (120) @(posedge clk);
		if (errors == 0 && expected_verts.size() == 0) begin
			$display("multi_material_cube_polylines_unit: match");
		end else begin
			$display("multi_material_cube_polylines_unit: mismatch");
		end
		$finish;
	end

	// Driver: a word stays on the bus until it is taken.
	always @(posedge clk) begin
		word_t w;
		if (arst_n) begin
			if (items.valid && items.ready) begin
				predict_polylines({items.cmd, items.corner_region_7, items.corner_region_6,
					items.corner_region_5, items.corner_region_4, items.corner_region_3,
					items.corner_region_2, items.corner_region_1, items.corner_region_0,
					items.priority_slot, items.priority_level});
			end
			if (!items.valid || items.ready) begin
				if (pending_words.size() > 0 && !hold_until_drained &&
					$urandom_range(99, 0) >= sender_idle_pct) begin
					w = pending_words.pop_front();
					items.valid <= 1'b1;
					items.cmd <= w.cmd;
					items.corner_region_0 <= w.crn[0]; items.corner_region_1 <= w.crn[1];
					items.corner_region_2 <= w.crn[2]; items.corner_region_3 <= w.crn[3];
					items.corner_region_4 <= w.crn[4]; items.corner_region_5 <= w.crn[5];
					items.corner_region_6 <= w.crn[6]; items.corner_region_7 <= w.crn[7];
					items.priority_slot <= w.slot;
					items.priority_level <= w.level;
				end else begin
					items.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and watchdog.
	always @(posedge clk) begin
		vert_t got;
		vert_t want;
		if (arst_n) begin
			if (results.valid && results.ready) begin
				got = {results.vertex_code, results.region_low, results.region_high,
					results.polyline_end, results.cube_last, results.center_error};
				if (expected_verts.size() == 0) begin
					report_mismatch("unexpected", got, '0);
				end else begin
					want = expected_verts.pop_front();
					if (got.code != want.code) report_mismatch("vertex_code", got, want);
					else if (got.lo != want.lo) report_mismatch("region_low", got, want);
					else if (got.hi != want.hi) report_mismatch("region_high", got, want);
					else if (got.pend != want.pend) report_mismatch("polyline_end", got, want);
					else if (got.last != want.last) report_mismatch("cube_last", got, want);
					else if (got.err != want.err) report_mismatch("center_error", got, want);
				end
			end
			results.ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
			if ((items.valid && items.ready) || (results.valid && results.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 5000) begin
				$display("multi_material_cube_polylines_unit: mismatch");
				$finish;
			end
		end
	end

endmodule

// ----- filelist.f -----
sv/mmcp_pkg.sv
sv/mmcp_in_if.sv
sv/mmcp_out_if.sv
sv/mmcp_front.sv
sv/mmcp_queue.sv
sv/mmcp_back.sv
sv/multi_material_cube_polylines_unit.sv
tb/tb.sv
